>>> design/device_circuit_breaker_backoff_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the device circuit breaker
// Concurrent assertion wrappers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DEVICE_CIRCUIT_BREAKER_BACKOFF_ASSERT_SVH
`define DEVICE_CIRCUIT_BREAKER_BACKOFF_ASSERT_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define DCBB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that cond never holds at a clock edge outside reset.
`define DCBB_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`else

`define DCBB_ASSERT(label, prop, msg)
`define DCBB_ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> design/dcbb_pkg.sv
// ----------------------------------------------------------------------------
// Device circuit breaker package
// Field widths, register map and reset values shared by the design files.
// ----------------------------------------------------------------------------
package dcbb_pkg;

	// Field widths of one access beat and one result beat.
	localparam int ADDR_W    = 8;
	localparam int NOW_W     = 32;
	localparam int LEVEL_W   = 3;
	localparam int RETRY_W   = 32;

	// Address bits 7..1 select the entry.
	localparam int ADDR_IDX_W   = ADDR_W - 1;
	localparam int NUM_ADDR_IDX = 2 ** ADDR_IDX_W;

	// Backoff delay register file.
	localparam int NUM_DELAYS = 6;
	localparam int DELAY_W    = 16;
	localparam int CFG_IDX_W  = 3;

	typedef logic [DELAY_W-1:0] delay_t;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_ONE   = 3'd0,
		REG_DELAY_TWO   = 3'd1,
		REG_DELAY_THREE = 3'd2,
		REG_DELAY_FOUR  = 3'd3,
		REG_DELAY_FIVE  = 3'd4,
		REG_DELAY_SIX   = 3'd5
	} cfg_reg_t;

	localparam delay_t DELAY_RESET [NUM_DELAYS] = '{
		16'd5, 16'd20, 16'd50, 16'd200, 16'd500, 16'd1000
	};

	// Defaults of the top-level parameters.
	localparam int NUM_DEVICES_DEF = 128;
	localparam int MAX_LEVEL_DEF   = 6;
	localparam int TICK_BITS_DEF   = 32;

endpackage

>>> design/dcbb_if.sv
// ----------------------------------------------------------------------------
// Device circuit breaker channels
// Valid/ready channels for access beats and result beats.
// ----------------------------------------------------------------------------
interface dcbb_in_if import dcbb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  device_address;
	logic [NOW_W-1:0]   now_tick;
	logic               transfer_ok;

	modport source (output valid, device_address, now_tick, transfer_ok, input ready);
	modport sink   (input valid, device_address, now_tick, transfer_ok, output ready);
endinterface

interface dcbb_out_if import dcbb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               result_code;
	logic               was_blocked;
	logic [LEVEL_W-1:0] level_after;
	logic [RETRY_W-1:0] retry_after;

	modport source (output valid, result_code, was_blocked, level_after, retry_after,
		input ready);
	modport sink   (input valid, result_code, was_blocked, level_after, retry_after,
		output ready);
endinterface

>>> design/device_circuit_breaker_backoff.sv
// ----------------------------------------------------------------------------
// Device circuit breaker with backoff
// Per-device failure level and retry tick, one table update per access beat.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------------
//  in_ch    | in  | valid / ready    | device_address, now_tick, transfer_ok
//  out_ch   | out | valid / ready    | result_code, was_blocked, level_after,
//           |     |                  | retry_after
//  cfg      | in  | cfg_we (no wait) | cfg_index, cfg_data
//
//  One access beat per cycle while out_ch keeps taking results; a taken beat
//  is registered in the lookup stage, then moves into the result register.
//  The entry table has one read and one write port: read at accept, written
//  when the beat moves into the result register, with a bypass for
//  back-to-back hits on the same entry.
//  Reset clears the per-entry valid bits at once: no clearing pass is needed.
//  A stalled result register holds the stage behind it, and in_ch.ready drops
//  only while both stages are full and out_ch is not taking a beat.
//
`include "device_circuit_breaker_backoff_assert.svh"

module device_circuit_breaker_backoff import dcbb_pkg::*; #(
	parameter int NUM_DEVICES = NUM_DEVICES_DEF,
	parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
	parameter int TICK_BITS   = TICK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dcbb_in_if.sink              in_ch,
	dcbb_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELAY_W-1:0]   cfg_data
);

	localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
	localparam int ENT_W = LEVEL_W + TICK_BITS;

	// ------------------------------------------------------------------
	// Delay registers
	// ------------------------------------------------------------------
	delay_t delay_q [NUM_DELAYS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DELAYS; i++) begin
				delay_q[i] <= DELAY_RESET[i];
			end
		end else if (cfg_we && (cfg_index <= REG_DELAY_SIX)) begin
			// Drop writes beyond the register list.
			delay_q[cfg_index] <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Address to entry index: bits 7..1, wrapped to the table depth
	// ------------------------------------------------------------------
	logic [IDX_W-1:0] idx_lut [NUM_ADDR_IDX];

	for (genvar v = 0; v < NUM_ADDR_IDX; v++) begin : g_idx_lut
		assign idx_lut[v] = IDX_W'(v % NUM_DEVICES);
	end

	logic [IDX_W-1:0] in_idx;
	assign in_idx = idx_lut[in_ch.device_address[ADDR_W-1:1]];

	// ------------------------------------------------------------------
	// Handshake control
	// ------------------------------------------------------------------
	logic s1_valid_q;
	logic out_valid_q;
	logic s1_adv;
	logic in_take;

	// Advance the lookup stage when the result register is free or draining.
	assign s1_adv       = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !s1_valid_q || s1_adv;
	assign in_take      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Entry table: {level, retry tick}, valid bits mark written entries
	// ------------------------------------------------------------------
	logic [ENT_W-1:0]       table_mem [NUM_DEVICES];
	logic [NUM_DEVICES-1:0] ent_valid_q;

	logic [IDX_W-1:0]       idx_s1;
	logic [TICK_BITS-1:0]   now_s1;
	logic                   ok_s1;
	logic [ENT_W-1:0]       rd_ent_s1;
	logic                   rd_vld_s1;
	logic                   fwd_s1;
	logic [LEVEL_W-1:0]     fwd_level_s1;
	logic [TICK_BITS-1:0]   fwd_retry_s1;

	logic [LEVEL_W-1:0]     lvl_old;
	logic [TICK_BITS-1:0]   retry_old;
	logic                   blocked;
	logic                   err;
	logic [LEVEL_W-1:0]     lvl_new;
	logic [LEVEL_W-1:0]     lvl_dec;
	logic [CFG_IDX_W-1:0]   dly_sel;
	logic [TICK_BITS-1:0]   retry_new;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			table_mem[idx_s1] <= {lvl_new, retry_new};
		end
		if (in_take) begin
			rd_ent_s1 <= table_mem[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
		end else if (s1_adv) begin
			ent_valid_q[idx_s1] <= 1'b1;
		end
	end

	// Capture the beat; bypass the entry the stage ahead is writing right now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (in_take) begin
			fwd_s1 <= s1_adv && (idx_s1 == in_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			idx_s1       <= in_idx;
			now_s1       <= TICK_BITS'(in_ch.now_tick);
			ok_s1        <= in_ch.transfer_ok;
			rd_vld_s1    <= ent_valid_q[in_idx];
			fwd_level_s1 <= lvl_new;
			fwd_retry_s1 <= retry_new;
		end
	end

	// ------------------------------------------------------------------
	// Breaker decision
	// ------------------------------------------------------------------
	always_comb begin
		if (fwd_s1) begin
			lvl_old   = fwd_level_s1;
			retry_old = fwd_retry_s1;
		end else begin
			lvl_old   = rd_vld_s1 ? rd_ent_s1[ENT_W-1 -: LEVEL_W] : '0;
			retry_old = rd_ent_s1[TICK_BITS-1:0];
		end

		// Refuse while a failed device's retry tick lies ahead (plain compare).
		blocked   = (lvl_old != '0) && (now_s1 < retry_old);
		lvl_new   = lvl_old;
		retry_new = retry_old;
		err       = 1'b1;

		if (lvl_old < LEVEL_W'(MAX_LEVEL)) begin
			lvl_dec = lvl_old;
		end else begin
			lvl_dec = LEVEL_W'(MAX_LEVEL - 1);
		end
		// Levels past the last register share its delay.
		if (lvl_dec >= LEVEL_W'(NUM_DELAYS)) begin
			dly_sel = CFG_IDX_W'(NUM_DELAYS - 1);
		end else begin
			dly_sel = CFG_IDX_W'(lvl_dec);
		end

		if (!blocked) begin
			if (ok_s1) begin
				lvl_new = '0;
				err     = 1'b0;
			end else begin
				lvl_new   = lvl_dec + LEVEL_W'(1);
				retry_new = TICK_BITS'(now_s1 + TICK_BITS'(delay_q[dly_sel]));
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic                 res_err_q;
	logic                 res_blk_q;
	logic [LEVEL_W-1:0]   res_lvl_q;
	logic [TICK_BITS-1:0] res_retry_q;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_err_q   <= err;
			res_blk_q   <= blocked;
			res_lvl_q   <= lvl_new;
			res_retry_q <= retry_new;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_code = res_err_q;
	assign out_ch.was_blocked = res_blk_q;
	assign out_ch.level_after = res_lvl_q;
	assign out_ch.retry_after = RETRY_W'(res_retry_q);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`DCBB_ASSERT(a_blocked_is_error,
		out_ch.valid && out_ch.was_blocked |-> out_ch.result_code,
		"blocked access reported as success")
	`DCBB_ASSERT(a_level_in_range,
		out_ch.valid |-> out_ch.level_after <= LEVEL_W'(MAX_LEVEL),
		"failure level above saturation")
	`DCBB_ASSERT(a_success_clears,
		out_ch.valid && !out_ch.result_code |-> out_ch.level_after == '0,
		"success left a nonzero level")
	`DCBB_ASSERT(a_failure_raises,
		out_ch.valid && out_ch.result_code && !out_ch.was_blocked |-> out_ch.level_after != '0,
		"failed access left level at zero")
	`DCBB_ASSERT(a_stall_holds_stage,
		s1_valid_q && out_valid_q && !out_ch.ready |=> s1_valid_q && $stable(idx_s1),
		"lookup stage moved while result stalled")

endmodule

>>> tb/sv/dcbb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Device circuit breaker checker
// Watches the access, result and configuration ports, keeps its own copy of
// the breaker table, and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module dcbb_checker import dcbb_pkg::*; #(
	parameter int NUM_DEVICES = NUM_DEVICES_DEF,
	parameter int MAX_LEVEL   = MAX_LEVEL_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dcbb_in_if                   in_ch,
	dcbb_out_if                  out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELAY_W-1:0]   cfg_data,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic               result_code;
		logic               was_blocked;
		logic [LEVEL_W-1:0] level_after;
		logic [RETRY_W-1:0] retry_after;
	} outcome_t;

	delay_t             backoff [NUM_DELAYS];
	logic [LEVEL_W-1:0] level_of [NUM_DEVICES];
	logic [RETRY_W-1:0] retry_of [NUM_DEVICES];
	outcome_t           expected_outcomes [$];
	outcome_t           due;
	outcome_t           seen;

	function automatic delay_t backoff_for(input int unsigned level);
		int unsigned k;
		if (level == 0)
			return '0;
		k = level - 1;
		if (k >= NUM_DELAYS)
			k = NUM_DELAYS - 1;
		return backoff[k];
	endfunction

	// Update the local table for one access and return what the block must report.
	function automatic outcome_t breaker_outcome(input logic [ADDR_W-1:0] addr,
		input logic [NOW_W-1:0] tick, input logic ok);
		int unsigned entry;
		int unsigned level;
		outcome_t    o;
		entry = addr[ADDR_W-1:1] % NUM_DEVICES;
		level = level_of[entry];
		o = '0;
		if (level > 0 && tick < retry_of[entry]) begin
			o.was_blocked = 1'b1;
			o.result_code = 1'b1;
		end else if (ok) begin
			level = 0;
		end else begin
			if (level < MAX_LEVEL)
				level++;
			retry_of[entry] = tick + backoff_for(level);
			o.result_code = 1'b1;
		end
		level_of[entry] = LEVEL_W'(level);
		o.level_after = LEVEL_W'(level);
		o.retry_after = retry_of[entry];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (level_of[i]) begin
				level_of[i] = '0;
				retry_of[i] = '0;
			end
			backoff = DELAY_RESET;
			expected_outcomes.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we && cfg_index < NUM_DELAYS)
				backoff[cfg_index] = cfg_data;
			if (in_ch.valid && in_ch.ready)
				expected_outcomes.push_back(breaker_outcome(in_ch.device_address,
					in_ch.now_tick, in_ch.transfer_ok));
			if (out_ch.valid && out_ch.ready) begin
				seen = {out_ch.result_code, out_ch.was_blocked, out_ch.level_after,
					out_ch.retry_after};
				if (expected_outcomes.size() == 0) begin
					$display("%0t: result beat with none expected: %h", $time, seen);
					fail_count++;
				end else begin
					due = expected_outcomes.pop_front();
					if (seen.result_code !== due.result_code) begin
						$display("%0t: result_code expected %0d got %0d", $time,
							due.result_code, seen.result_code);
						fail_count++;
					end
					if (seen.was_blocked !== due.was_blocked) begin
						$display("%0t: was_blocked expected %0d got %0d", $time,
							due.was_blocked, seen.was_blocked);
						fail_count++;
					end
					if (seen.level_after !== due.level_after) begin
						$display("%0t: level_after expected %0d got %0d", $time,
							due.level_after, seen.level_after);
						fail_count++;
					end
					if (seen.retry_after !== due.retry_after) begin
						$display("%0t: retry_after expected %h got %h", $time,
							due.retry_after, seen.retry_after);
						fail_count++;
					end
				end
			end
			pending = expected_outcomes.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Device circuit breaker testbench
// Drives access beats with random gaps and result back-pressure, walks the
// backoff registers through several settings, and takes the verdict from the
// checker that sits beside the block.
// ----------------------------------------------------------------------------
module testbench;
	import dcbb_pkg::*;

	// Indexes past the register file; writes there must leave every delay alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int PHASE_ITEMS = 100;
	localparam int POOL_SIZE   = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DELAY_W-1:0]   cfg_data;
	int                   fail_count;
	int                   pending;

	// Both sides run without idling while calm is set.
	bit                   calm;
	// Entries whose retry tick has been written by a failure.
	bit                   written [NUM_ADDR_IDX];
	delay_t               cur_delay [NUM_DELAYS];
	delay_t               new_delay [NUM_DELAYS];
	logic [NOW_W-1:0]     run_tick;
	logic [ADDR_IDX_W-1:0] pool [POOL_SIZE];
	int                   k;

	dcbb_in_if  in_ch ();
	dcbb_out_if out_ch ();

	device_circuit_breaker_backoff dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dcbb_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Every task starts and ends on a falling edge, where all inputs change.

	// Offer one access beat after a random gap and hold it until accepted.
	// An entry that never failed gets a failure first, so that its retry tick
	// is always written before anything reports it.
	task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [NOW_W-1:0] tick,
		input logic ok);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (!written[addr[ADDR_W-1:1]]) begin
			ok = 1'b0;
			written[addr[ADDR_W-1:1]] = 1'b1;
		end
		if (gap != 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid          = 1'b1;
		in_ch.device_address = addr;
		in_ch.now_tick       = tick;
		in_ch.transfer_ok    = ok;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Drop valid and hold until every predicted result has come back.
	task automatic wait_drain();
		int guard;
		guard = 0;
		in_ch.valid = 1'b0;
		while (pending != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
	endtask

	task automatic set_delays(input delay_t d [NUM_DELAYS]);
		write_reg(REG_DELAY_ONE,   d[0]);
		write_reg(REG_DELAY_TWO,   d[1]);
		write_reg(REG_DELAY_THREE, d[2]);
		write_reg(REG_DELAY_FOUR,  d[3]);
		write_reg(REG_DELAY_FIVE,  d[4]);
		write_reg(REG_DELAY_SIX,   d[5]);
		cur_delay = d;
	endtask

	// One random phase: a small pool of devices hit with a slowly advancing
	// tick, so that the breakers open, block, back off and close again. Mix in
	// stray addresses and ticks drawn from the whole range as noise.
	task automatic run_phase(input logic [NOW_W-1:0] start);
		int               n;
		int unsigned      maxd;
		logic [ADDR_W-1:0] addr;
		logic [NOW_W-1:0] tick;
		maxd = 0;
		foreach (cur_delay[i])
			if (cur_delay[i] > maxd)
				maxd = cur_delay[i];
		foreach (pool[i])
			pool[i] = ADDR_IDX_W'($urandom_range(0, NUM_ADDR_IDX - 1));
		run_tick = start;
		for (n = 0; n < PHASE_ITEMS; n++) begin
			// Run a stretch back to back, and pause once mid-phase for a full drain.
			calm = (n >= 20 && n < 40);
			if (n == 60)
				wait_drain();
			if ($urandom_range(0, 7) == 0)
				addr = ADDR_W'($urandom_range(0, 255));
			else
				addr = {pool[$urandom_range(0, POOL_SIZE - 1)], 1'($urandom_range(0, 1))};
			if ($urandom_range(0, 9) == 0) begin
				tick = $urandom;
			end else begin
				run_tick += $urandom_range(0, maxd / 2 + 1);
				tick = run_tick;
			end
			send_access(addr, tick, $urandom_range(0, 2) == 0);
		end
		calm = 1'b0;
		wait_drain();
	endtask

	// Result side: stall a random number of cycles per beat, then take it.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				out_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		in_ch.valid          = 1'b0;
		in_ch.device_address = '0;
		in_ch.now_tick       = '0;
		in_ch.transfer_ok    = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_DELAY_ONE;
		cfg_data             = '0;
		calm                 = 1'b0;
		arst_n               = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, on the reset delays.
		// Open entry 0, hit it while blocked (with both transfer results), then
		// close it at the retry tick and succeed once more at level zero.
		send_access(8'h00, 32'd0, 1'b0);
		send_access(8'h01, 32'd4, 1'b1);
		send_access(8'h01, 32'd4, 1'b0);
		send_access(8'h00, 32'd5, 1'b1);
		send_access(8'h00, 32'd5, 1'b1);
		// Wrap the retry tick on the top entry; the plain compare then lets the
		// next failure through, and a small tick after it is blocked.
		send_access(8'hFF, 32'hFFFF_FFFF, 1'b0);
		send_access(8'hFE, 32'hFFFF_FFFF, 1'b0);
		send_access(8'hFE, 32'd3, 1'b1);
		// Climb one entry to the saturated level and past it, then clear it.
		for (k = 0; k < 8; k++)
			send_access(8'h80, 32'h0001_0000 + k * 32'h1000, 1'b0);
		send_access(8'h81, 32'h0001_8000, 1'b1);
		send_access(8'h80, 32'h0001_8000, 1'b0);
		// Success on an entry that has never failed is turned into a failure.
		send_access(8'h02, 32'd0, 1'b1);
		send_access(8'h03, 32'd100, 1'b1);
		send_access(8'h7F, 32'h8000_0000, 1'b0);
		send_access(8'h7E, 32'h7FFF_FFFF, 1'b1);
		wait_drain();

		// Zero backoff: a failure blocks only a later access whose tick lies below it.
		new_delay = '{default: 16'h0000};
		set_delays(new_delay);
		run_phase(32'h0000_1000);

		// Full-scale backoff; a stray write past the register file follows.
		new_delay = '{default: 16'hFFFF};
		set_delays(new_delay);
		write_reg(REG_SPARE_LO, DELAY_W'($urandom_range(0, 65535)));
		run_phase($urandom);

		// Short delays near the top of the tick range, so retry ticks wrap.
		foreach (new_delay[i])
			new_delay[i] = DELAY_W'($urandom_range(0, 15));
		set_delays(new_delay);
		write_reg(REG_SPARE_HI, 16'hFFFF);
		run_phase(32'hFFFF_FF00);

		foreach (new_delay[i])
			new_delay[i] = DELAY_W'($urandom_range(0, 65535));
		set_delays(new_delay);
		run_phase($urandom);

		// Let the pipeline settle before the verdict.
		repeat (4) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
